// ===== rtl/pdtq_pkg.sv =====
// ----------------------------------------------------------------------------
// pdtq_pkg
// Shared widths, codes and controller/datapath interface types for the
// pull-served drop-tail packet queue.
// ----------------------------------------------------------------------------
package pdtq_pkg;

  localparam int ID_W    = 32;
  localparam int LEN_W   = 16;
  localparam int ENTRY_W = ID_W + LEN_W;
  localparam int CAP_W   = 7;
  localparam int QLEN_W  = 7;
  localparam int CNT_W   = 32;

  localparam int DEFAULT_QUEUE_DEPTH = 64;
  localparam logic [CAP_W-1:0] CAPACITY_RESET = 7'd64;

  typedef enum logic {
    KIND_ARRIVAL = 1'b0,
    KIND_REQUEST = 1'b1
  } pdtq_kind_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } pdtq_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_item;
    logic load_mem;
  } pdtq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pop_req;
  } pdtq_status_t;

endpackage

// ===== rtl/pdtq_ram.sv =====
// ----------------------------------------------------------------------------
// pdtq_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module pdtq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/pdtq_ctrl.sv =====
// ----------------------------------------------------------------------------
// pdtq_ctrl
// Controller: handshakes on both channels and sequencing of the store read
// state that a pop from the packet store needs.
// ----------------------------------------------------------------------------
module pdtq_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  pdtq_pkg::pdtq_status_t status_i,
  output pdtq_pkg::pdtq_cmd_t    cmd_o
);
  import pdtq_pkg::*;

  pdtq_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        accept;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && status_i.pop_req) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // In the idle state a new word may enter whenever the output register is
  // empty or is being emptied in this cycle.
  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    out_valid_d    = out_valid_q;
    accept         = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o     = !out_valid_q || out_ready_i;
        accept         = in_valid_i && in_ready_o;
        cmd_o.take_item = accept;
        if (accept && !status_i.pop_req) begin
          out_valid_d = 1'b1;
        end
      end
      ST_READ: begin
        cmd_o.load_mem = 1'b1;
        out_valid_d    = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/pdtq_datapath.sv =====
// ----------------------------------------------------------------------------
// pdtq_datapath
// Queue pointers, occupancy, waiting flag, drop counter, capacity register,
// the packet store and the result register.
// ----------------------------------------------------------------------------
module pdtq_datapath #(
  parameter int QueueDepth = pdtq_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [pdtq_pkg::CAP_W-1:0]  cfg_wdata_i,
  input  logic                        kind_i,
  input  logic [pdtq_pkg::ID_W-1:0]   packet_id_i,
  input  logic [pdtq_pkg::LEN_W-1:0]  bit_length_i,
  input  pdtq_pkg::pdtq_cmd_t         cmd_i,
  output pdtq_pkg::pdtq_status_t      status_o,
  output logic                        sent_o,
  output logic [pdtq_pkg::ID_W-1:0]   sent_packet_id_o,
  output logic [pdtq_pkg::LEN_W-1:0]  sent_bit_length_o,
  output logic                        dropped_o,
  output logic                        bad_length_o,
  output logic [pdtq_pkg::QLEN_W-1:0] queue_length_o,
  output logic [pdtq_pkg::CNT_W-1:0]  drop_count_o
);
  import pdtq_pkg::*;

  localparam int AW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CW = $clog2(QueueDepth + 1);
  localparam int LW = (CW > CAP_W) ? CW : CAP_W;
  localparam int SW = AW + 2;

  logic [CAP_W-1:0]   capacity_q;
  logic [AW-1:0]      head_q, head_d, head_next, tail;
  logic [CW-1:0]      occ_q, occ_d;
  logic               waiting_q, waiting_d;
  logic [CNT_W-1:0]   drops_q, drops_d, drops_inc;
  logic [LW-1:0]      limit, occ_ext;
  logic [SW-1:0]      tail_sum;
  logic               has_room;
  logic               mem_we, mem_re;
  logic [ENTRY_W-1:0] mem_rdata;

  logic               sent_q, sent_d;
  logic [ID_W-1:0]    id_q, id_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic               dropped_q, dropped_d;
  logic               bad_q, bad_d;
  logic [QLEN_W-1:0]  qlen_q, qlen_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  always_comb begin
    occ_ext   = LW'(occ_q);
    limit     = (LW'(capacity_q) < LW'(QueueDepth)) ? LW'(capacity_q) : LW'(QueueDepth);
    has_room  = occ_ext < limit;
    head_next = (head_q == AW'(QueueDepth - 1)) ? '0 : head_q + 1'b1;
    tail_sum  = SW'(head_q) + SW'(occ_q);
    if (tail_sum >= SW'(QueueDepth)) begin
      tail_sum = tail_sum - SW'(QueueDepth);
    end
    tail      = tail_sum[AW-1:0];
    drops_inc = (drops_q == '1) ? drops_q : drops_q + 1'b1;
    status_o.pop_req = (kind_i == KIND_REQUEST) && (occ_q != '0);
  end

  always_comb begin
    head_d    = head_q;
    occ_d     = occ_q;
    waiting_d = waiting_q;
    drops_d   = drops_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    sent_d    = sent_q;
    id_d      = id_q;
    len_d     = len_q;
    dropped_d = dropped_q;
    bad_d     = bad_q;
    qlen_d    = qlen_q;
    cnt_d     = cnt_q;
    if (cmd_i.take_item) begin
      sent_d    = 1'b0;
      id_d      = '0;
      len_d     = '0;
      dropped_d = 1'b0;
      bad_d     = 1'b0;
      qlen_d    = occ_ext[QLEN_W-1:0];
      cnt_d     = drops_q;
      if (kind_i == KIND_ARRIVAL) begin
        if (bit_length_i == '0) begin
          dropped_d = 1'b1;
          bad_d     = 1'b1;
          drops_d   = drops_inc;
          cnt_d     = drops_inc;
        end else if (has_room) begin
          mem_we = 1'b1;
          // A waiting server implies an empty queue, so the head is this word.
          if (waiting_q) begin
            sent_d    = 1'b1;
            id_d      = packet_id_i;
            len_d     = bit_length_i;
            head_d    = head_next;
            waiting_d = 1'b0;
          end else begin
            occ_d = occ_q + 1'b1;
          end
        end else begin
          dropped_d = 1'b1;
          drops_d   = drops_inc;
          cnt_d     = drops_inc;
        end
      end else if (occ_q != '0) begin
        mem_re    = 1'b1;
        head_d    = head_next;
        occ_d     = occ_q - 1'b1;
        waiting_d = 1'b0;
      end else begin
        waiting_d = 1'b1;
      end
    end
    if (cmd_i.load_mem) begin
      sent_d = 1'b1;
      id_d   = mem_rdata[ENTRY_W-1:LEN_W];
      len_d  = mem_rdata[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAPACITY_RESET;
      head_q     <= '0;
      occ_q      <= '0;
      waiting_q  <= 1'b0;
      drops_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        capacity_q <= cfg_wdata_i;
      end
      head_q    <= head_d;
      occ_q     <= occ_d;
      waiting_q <= waiting_d;
      drops_q   <= drops_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sent_q    <= sent_d;
    id_q      <= id_d;
    len_q     <= len_d;
    dropped_q <= dropped_d;
    bad_q     <= bad_d;
    qlen_q    <= qlen_d;
    cnt_q     <= cnt_d;
  end

  pdtq_ram #(
    .Width (ENTRY_W),
    .Depth (QueueDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (tail),
    .wdata_i ({packet_id_i, bit_length_i}),
    .re_i    (mem_re),
    .raddr_i (head_q),
    .rdata_o (mem_rdata)
  );

  assign sent_o            = sent_q;
  assign sent_packet_id_o  = id_q;
  assign sent_bit_length_o = len_q;
  assign dropped_o         = dropped_q;
  assign bad_length_o      = bad_q;
  assign queue_length_o    = qlen_q;
  assign drop_count_o      = cnt_q;

endmodule

// ===== rtl/pull_drop_tail_queue_unit.sv =====
// ----------------------------------------------------------------------------
// pull_drop_tail_queue_unit
// Drop-tail packet FIFO whose head is pulled by server requests.
// Timing: arrivals and requests on an empty queue register their result in
//   the cycle after acceptance; a pop reads the store before registering it.
// Throughput: one word per cycle while the receiver keeps up, except that the
//   input is held off after each pop while the store returns the head entry.
// Reset: rst_ni clears the queue, waiting flag and drop count and sets the
//   capacity to 64; the packet store itself is not cleared.
// ----------------------------------------------------------------------------
module pull_drop_tail_queue_unit #(
  parameter int QueueDepth = pdtq_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [pdtq_pkg::CAP_W-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        kind_i,
  input  logic [pdtq_pkg::ID_W-1:0]   packet_id_i,
  input  logic [pdtq_pkg::LEN_W-1:0]  bit_length_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        sent_o,
  output logic [pdtq_pkg::ID_W-1:0]   sent_packet_id_o,
  output logic [pdtq_pkg::LEN_W-1:0]  sent_bit_length_o,
  output logic                        dropped_o,
  output logic                        bad_length_o,
  output logic [pdtq_pkg::QLEN_W-1:0] queue_length_o,
  output logic [pdtq_pkg::CNT_W-1:0]  drop_count_o
);
  import pdtq_pkg::*;

  pdtq_cmd_t    cmd;
  pdtq_status_t status;

  pdtq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  pdtq_datapath #(
    .QueueDepth (QueueDepth)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .kind_i            (kind_i),
    .packet_id_i       (packet_id_i),
    .bit_length_i      (bit_length_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .sent_o            (sent_o),
    .sent_packet_id_o  (sent_packet_id_o),
    .sent_bit_length_o (sent_bit_length_o),
    .dropped_o         (dropped_o),
    .bad_length_o      (bad_length_o),
    .queue_length_o    (queue_length_o),
    .drop_count_o      (drop_count_o)
  );

`ifndef SYNTHESIS
  // The input side never opens while a result is stuck in the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (!out_valid_o || out_ready_i))
    else $error("input accepted over a stalled result");

  // A pop blocks the input while the store is read, then delivers a packet.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.take_item && status.pop_req) |=> (!in_ready_o && cmd.load_mem))
    else $error("pop did not sequence through the store read");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_mem |=> (out_valid_o && sent_o && !dropped_o))
    else $error("store read did not produce a sent word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!(sent_o && dropped_o) && (!bad_length_o || dropped_o)))
    else $error("inconsistent result flags");
`endif

endmodule

// ===== bench/pull_drop_tail_queue_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pull_drop_tail_queue_unit_test
// Self-checking bench for the pull-served drop-tail packet queue. Directed
// words cover empty-queue requests, zero lengths, extreme ids and lengths,
// shrinking and oversized capacities; bursty random traffic then runs under
// several capacity settings and handshake idling patterns. A tracker predicts
// every result word and compares it against the block's output.
// ----------------------------------------------------------------------------
module pull_drop_tail_queue_unit_test;
  import pdtq_pkg::*;

  localparam int unsigned DEPTH = DEFAULT_QUEUE_DEPTH;
  // Generous against the longest random stall on either side.
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES = 4;

  typedef struct packed {
    logic              sent;
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  len;
    logic              dropped;
    logic              bad_len;
    logic [QLEN_W-1:0] qlen;
    logic [CNT_W-1:0]  drops;
  } queue_result_t;

  class queue_tracker;
    int unsigned     capacity = 32'(CAPACITY_RESET);
    logic [ID_W-1:0]  held_id[DEPTH];
    logic [LEN_W-1:0] held_len[DEPTH];
    int unsigned     head = 0;
    int unsigned     occupancy = 0;
    bit              server_waiting = 0;
    logic [CNT_W-1:0] drop_total = '0;
    queue_result_t   awaited[$];
    int unsigned     mismatches = 0;

    function int unsigned words_in_flight();
      return awaited.size();
    endfunction

    function void take_head(inout queue_result_t r);
      r.sent = 1'b1;
      r.id = held_id[head];
      r.len = held_len[head];
      head = (head + 1) % DEPTH;
      occupancy--;
    endfunction

    function void note_word(pdtq_kind_e kind, logic [ID_W-1:0] id, logic [LEN_W-1:0] len);
      queue_result_t r;
      int unsigned limit;
      int unsigned tail;
      r = '0;
      limit = (capacity < DEPTH) ? capacity : DEPTH;
      r.qlen = occupancy[QLEN_W-1:0];
      if (kind == KIND_ARRIVAL) begin
        if (len == '0) begin
          r.dropped = 1'b1;
          r.bad_len = 1'b1;
          if (drop_total != '1) drop_total++;
        end else if (occupancy < limit) begin
          tail = (head + occupancy) % DEPTH;
          held_id[tail] = id;
          held_len[tail] = len;
          occupancy++;
          // A pending pull takes the oldest packet straight away.
          if (server_waiting) begin
            take_head(r);
            server_waiting = 0;
          end
        end else begin
          r.dropped = 1'b1;
          if (drop_total != '1) drop_total++;
        end
      end else if (occupancy > 0) begin
        take_head(r);
        server_waiting = 0;
      end else begin
        server_waiting = 1;
      end
      r.drops = drop_total;
      awaited.push_back(r);
    endfunction

    function void show(string tag, queue_result_t r);
      $display("  %s sent=%0d id=%h len=%h dropped=%0d bad_length=%0d",
               tag, r.sent, r.id, r.len, r.dropped, r.bad_len);
      $display("    queue_length=%0d drop_count=%0d", r.qlen, r.drops);
    endfunction

    function void check_word(queue_result_t got);
      queue_result_t want;
      if (awaited.size() == 0) begin
        if (mismatches < 10) begin
          $display("result word arrived with nothing outstanding");
          show("actual  ", got);
        end
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      if (got.sent !== want.sent || got.id !== want.id || got.len !== want.len ||
          got.dropped !== want.dropped || got.bad_len !== want.bad_len ||
          got.qlen !== want.qlen || got.drops !== want.drops) begin
        if (mismatches < 10) begin
          $display("result word mismatch");
          show("expected", want);
          show("actual  ", got);
        end
        mismatches++;
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [CAP_W-1:0]  cfg_wdata_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic              kind_i = 1'b0;
  logic [ID_W-1:0]   packet_id_i = '0;
  logic [LEN_W-1:0]  bit_length_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic              sent_o;
  logic [ID_W-1:0]   sent_packet_id_o;
  logic [LEN_W-1:0]  sent_bit_length_o;
  logic              dropped_o;
  logic              bad_length_o;
  logic [QLEN_W-1:0] queue_length_o;
  logic [CNT_W-1:0]  drop_count_o;

  queue_tracker  tracker;
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_idle_pct = 0;
  int unsigned   stall_cycles = 0;
  queue_result_t seen;

  pull_drop_tail_queue_unit u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .kind_i            (kind_i),
    .packet_id_i       (packet_id_i),
    .bit_length_i      (bit_length_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .sent_o            (sent_o),
    .sent_packet_id_o  (sent_packet_id_o),
    .sent_bit_length_o (sent_bit_length_o),
    .dropped_o         (dropped_o),
    .bad_length_o      (bad_length_o),
    .queue_length_o    (queue_length_o),
    .drop_count_o      (drop_count_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Result checking, receiver stalls and the no-progress watchdog.
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      seen.sent = sent_o;
      seen.id = sent_packet_id_o;
      seen.len = sent_bit_length_o;
      seen.dropped = dropped_o;
      seen.bad_len = bad_length_o;
      seen.qlen = queue_length_o;
      seen.drops = drop_count_o;
      tracker.check_word(seen);
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    if (stall_cycles >= STALL_LIMIT) begin
      $display("[pull_drop_tail_queue_unit] ERROR");
      $finish;
    end
  end

  task automatic send_word(input pdtq_kind_e kind, input logic [ID_W-1:0] id,
                           input logic [LEN_W-1:0] len);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    packet_id_i <= id;
    bit_length_i <= len;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    tracker.note_word(kind, id, len);
  endtask

  // Hold the sender until every outstanding word has come back, then let
  // the block's pipeline go quiet.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (tracker.words_in_flight() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.capacity = 32'(value);
  endtask

  task automatic directed_words();
    send_word(KIND_REQUEST, 32'h0, 16'h0);
    send_word(KIND_ARRIVAL, 32'hDEAD_BEEF, 16'h0);
    send_word(KIND_ARRIVAL, 32'hFFFF_FFFF, 16'hFFFF);
    send_word(KIND_ARRIVAL, 32'h0, 16'h1);
    send_word(KIND_ARRIVAL, 32'hA5A5_A5A5, 16'h8000);
    send_word(KIND_ARRIVAL, 32'h5A5A_5A5A, 16'h7FFF);
    repeat (3) send_word(KIND_REQUEST, 32'hFFFF_FFFF, 16'hFFFF);
    send_word(KIND_REQUEST, 32'h0, 16'h0);
    send_word(KIND_REQUEST, 32'h0, 16'h0);
    send_word(KIND_ARRIVAL, 32'h1234_5678, 16'h1);
    repeat (4) send_word(KIND_ARRIVAL, $urandom, LEN_W'($urandom_range(65535, 1)));
    // Shrinking the capacity below the occupancy drops new arrivals.
    write_capacity(7'd1);
    send_word(KIND_ARRIVAL, $urandom, 16'h0040);
    // With no room at all, a pending pull stays pending.
    write_capacity(7'd0);
    repeat (4) send_word(KIND_REQUEST, 32'h0, 16'h0);
    send_word(KIND_REQUEST, 32'h0, 16'h0);
    send_word(KIND_ARRIVAL, $urandom, 16'h0100);
    write_capacity(7'd127);
    send_word(KIND_ARRIVAL, $urandom, 16'h0200);
  endtask

  // Bursty traffic: runs of mostly arrivals fill the queue to its limit,
  // runs of mostly pulls empty it and leave the server waiting.
  task automatic random_traffic(input int unsigned words);
    int unsigned run_left;
    int unsigned arrive_pct;
    int unsigned roll;
    logic [LEN_W-1:0] len;
    run_left = 0;
    arrive_pct = 50;
    for (int unsigned n = 0; n < words; n++) begin
      if (run_left == 0) begin
        run_left = $urandom_range(60, 1);
        case ($urandom_range(2))
          0: arrive_pct = 15;
          1: arrive_pct = 50;
          default: arrive_pct = 85;
        endcase
      end
      run_left--;
      if ($urandom_range(199) == 0) drain();
      roll = $urandom_range(99);
      if (roll < 4) begin
        len = '0;
      end else if (roll < 7) begin
        len = '1;
      end else begin
        len = LEN_W'($urandom_range(65535, 1));
      end
      if ($urandom_range(99) < arrive_pct) begin
        send_word(KIND_ARRIVAL, $urandom, len);
      end else begin
        send_word(KIND_REQUEST, $urandom, len);
      end
    end
  endtask

  initial begin
    tracker = new;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_words();

    send_idle_pct = 34;
    recv_idle_pct = 58;
    write_capacity(7'd64);
    random_traffic(320);
    write_capacity(7'd1);
    random_traffic(320);

    send_idle_pct = 58;
    recv_idle_pct = 34;
    write_capacity(7'd65);
    random_traffic(320);
    write_capacity(7'd0);
    random_traffic(200);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_capacity(CAP_W'($urandom_range(63, 2)));
    random_traffic(320);
    write_capacity(7'd127);
    random_traffic(320);

    drain();
    if (tracker.mismatches == 0) begin
      $display("[pull_drop_tail_queue_unit] OK");
    end else begin
      $display("[pull_drop_tail_queue_unit] ERROR");
    end
    $finish;
  end

endmodule
